// File: src/clp_pkg.sv
// shared types and constants of the contact level partitioner
package clp_pkg;

  localparam int PORT_BODY_W = 8;
  localparam int TAG_W       = 6;
  localparam int REM_W       = 6;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_STATIC = 2'd2,
    CMD_NEXT   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                   command;
    logic [PORT_BODY_W-1:0] first_body;
    logic [PORT_BODY_W-1:0] second_body;
    logic                   first_movable;
    logic                   second_movable;
  } in_word_t;

  typedef struct packed {
    logic                   has_contact;
    logic [TAG_W-1:0]       contact_tag;
    logic [PORT_BODY_W-1:0] contact_first;
    logic [PORT_BODY_W-1:0] contact_second;
    logic                   has_body;
    logic [PORT_BODY_W-1:0] level_body;
    logic [REM_W-1:0]       remaining;
    logic                   last;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic append;
    logic start;
    logic rd_contact;
    logic ld_contact;
    logic srch_init;
    logic srch_rd;
    logic srch_cmp;
    logic take;
    logic skip;
    logic rd_last;
    logic wr_slot;
    logic pass2;
    logic finish;
    logic emit_rd;
    logic emit_ld;
    logic emit_next;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic i_lt_count;
    logic j_lt_len;
    logic pass_two;
    logic take;
    logic k_last;
    logic out_fire;
  } dp_stat_t;

endpackage

// File: src/clp_chan_if.sv
// valid/ready channel carrying one word
interface clp_chan_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/clp_dp.sv
// datapath: contact store, level lists, result buffer and counters
module clp_dp #(
  parameter int MAX_CONTACTS = 32,
  parameter int BODY_ID_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  clp_pkg::in_word_t    in_word,
  input  clp_pkg::ctrl_cmd_t   cmd,
  output clp_pkg::dp_stat_t    stat,
  clp_chan_if.source           rsp
);

  localparam int CW = $clog2(MAX_CONTACTS + 1);
  localparam int IW = $clog2(MAX_CONTACTS);
  localparam int BW = BODY_ID_BITS;
  localparam int LD = 2 ** (IW + 1);

  typedef struct packed {
    logic [BW-1:0]             b1;
    logic [BW-1:0]             b2;
    logic                      m1;
    logic                      m2;
    logic [clp_pkg::TAG_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic [clp_pkg::TAG_W-1:0] tag;
    logic [BW-1:0]             b1;
    logic [BW-1:0]             b2;
    logic                      hasb;
    logic [BW-1:0]             body;
  } res_t;

  entry_t        store [MAX_CONTACTS];
  logic [BW-1:0] lists [LD];
  res_t          rbuf  [MAX_CONTACTS];

  entry_t        st_q;
  logic [BW-1:0] ls_q;
  res_t          rb_q;
  entry_t        cur;

  logic [CW-1:0] count;
  logic [CW-1:0] prev_cnt;
  logic [CW-1:0] nb;
  logic [CW-1:0] n;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [CW-1:0] k;
  logic          sel;
  logic          pass_two;
  logic          mode_next;
  logic          f1;
  logic          f2;
  logic          out_valid;
  clp_pkg::out_word_t out_q;

  logic          bank;
  logic [CW-1:0] len;
  logic          take;
  logic [BW-1:0] body;
  logic          n_zero;
  logic          k_last;
  entry_t        new_entry;

  assign bank   = pass_two ? ~sel : sel;
  assign len    = pass_two ? nb : prev_cnt;
  assign n_zero = (n == '0);
  assign k_last = n_zero || (CW'(k + 1'b1) == n);

  always_comb begin
    if (pass_two) begin
      take = f1 & f2;
    end else if (mode_next) begin
      take = f1 | f2;
    end else begin
      take = ~(cur.m1 & cur.m2);
    end
    if (mode_next) begin
      body = f1 ? cur.b2 : cur.b1;
    end else begin
      body = cur.m1 ? cur.b1 : cur.b2;
    end
  end

  always_comb begin
    new_entry.b1  = BW'(in_word.first_body);
    new_entry.b2  = BW'(in_word.second_body);
    new_entry.m1  = in_word.first_movable;
    new_entry.m2  = in_word.second_movable;
    new_entry.tag = clp_pkg::TAG_W'(count);
  end

  assign stat.i_lt_count = (i < count);
  assign stat.j_lt_len   = (j < len);
  assign stat.pass_two   = pass_two;
  assign stat.take       = take;
  assign stat.k_last     = k_last;
  assign stat.out_fire   = out_valid & rsp.ready;

  assign rsp.valid = out_valid;
  assign rsp.data  = out_q;

  // contact store
  always_ff @(posedge clk) begin
    if (cmd.append && count < CW'(MAX_CONTACTS)) begin
      store[count[IW-1:0]] <= new_entry;
    end else if (cmd.wr_slot) begin
      store[i[IW-1:0]] <= st_q;
    end
    if (cmd.rd_last) begin
      st_q <= store[count[IW-1:0]];
    end else if (cmd.rd_contact) begin
      st_q <= store[i[IW-1:0]];
    end
  end

  // level lists, two banks: previous and fresh
  always_ff @(posedge clk) begin
    if (cmd.take && !pass_two) begin
      lists[{~sel, nb[IW-1:0]}] <= body;
    end
    if (cmd.srch_rd) begin
      ls_q <= lists[{bank, j[IW-1:0]}];
    end
  end

  // result buffer
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rbuf[n[IW-1:0]] <= '{tag: cur.tag, b1: cur.b1, b2: cur.b2,
                           hasb: ~pass_two, body: pass_two ? '0 : body};
    end
    if (cmd.emit_rd) begin
      rb_q <= rbuf[k[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      prev_cnt  <= '0;
      sel       <= 1'b0;
      out_valid <= 1'b0;
      pass_two  <= 1'b0;
      mode_next <= 1'b0;
      nb        <= '0;
      n         <= '0;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      f1        <= 1'b0;
      f2        <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count <= '0;
      end
      if (cmd.append && count < CW'(MAX_CONTACTS)) begin
        count <= CW'(count + 1'b1);
      end
      if (cmd.start) begin
        i         <= '0;
        n         <= '0;
        nb        <= '0;
        pass_two  <= 1'b0;
        mode_next <= (in_word.command == clp_pkg::CMD_NEXT);
      end
      if (cmd.ld_contact) begin
        cur <= st_q;
      end
      if (cmd.srch_init) begin
        j  <= '0;
        f1 <= 1'b0;
        f2 <= 1'b0;
      end
      if (cmd.srch_cmp) begin
        if (ls_q == cur.b1) f1 <= 1'b1;
        if (ls_q == cur.b2) f2 <= 1'b1;
        j <= CW'(j + 1'b1);
      end
      if (cmd.take) begin
        n     <= CW'(n + 1'b1);
        count <= CW'(count - 1'b1);
        if (!pass_two) begin
          nb <= CW'(nb + 1'b1);
        end
      end
      if (cmd.skip) begin
        i <= CW'(i + 1'b1);
      end
      if (cmd.pass2) begin
        pass_two <= 1'b1;
        i        <= '0;
      end
      if (cmd.finish) begin
        sel      <= ~sel;
        prev_cnt <= nb;
        k        <= '0;
      end
      if (cmd.emit_ld) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit_next) begin
        k <= CW'(k + 1'b1);
      end
    end
  end

  // output word, payload register
  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      out_q.has_contact    <= ~n_zero;
      out_q.contact_tag    <= n_zero ? '0 : rb_q.tag;
      out_q.contact_first  <= n_zero ? '0 : clp_pkg::PORT_BODY_W'(rb_q.b1);
      out_q.contact_second <= n_zero ? '0 : clp_pkg::PORT_BODY_W'(rb_q.b2);
      out_q.has_body       <= n_zero ? 1'b0 : rb_q.hasb;
      out_q.level_body     <= n_zero ? '0 : clp_pkg::PORT_BODY_W'(rb_q.body);
      out_q.remaining      <= clp_pkg::REM_W'(count);
      out_q.last           <= k_last;
    end
  end

endmodule

// File: src/clp_ctrl.sv
// controller: sequences table scans, list searches and result emission
module clp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  clp_pkg::cmd_t       req_cmd,
  output logic                req_ready,
  input  clp_pkg::dp_stat_t   stat,
  output clp_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_LOAD, ST_SRCH, ST_CMP, ST_DECIDE, ST_RD_LAST,
    ST_WR_SLOT, ST_FINISH, ST_E_RD, ST_E_LD, ST_E_WAIT
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (req_cmd)
            clp_pkg::CMD_CLEAR:  cmd.clear  = 1'b1;
            clp_pkg::CMD_APPEND: cmd.append = 1'b1;
            default: begin
              cmd.start  = 1'b1;
              state_next = ST_SCAN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (stat.i_lt_count) begin
          cmd.rd_contact = 1'b1;
          state_next     = ST_LOAD;
        end else if (stat.pass_two) begin
          state_next = ST_FINISH;
        end else begin
          cmd.pass2 = 1'b1;
        end
      end
      ST_LOAD: begin
        cmd.ld_contact = 1'b1;
        cmd.srch_init  = 1'b1;
        state_next     = ST_SRCH;
      end
      ST_SRCH: begin
        if (stat.j_lt_len) begin
          cmd.srch_rd = 1'b1;
          state_next  = ST_CMP;
        end else begin
          state_next = ST_DECIDE;
        end
      end
      ST_CMP: begin
        cmd.srch_cmp = 1'b1;
        state_next   = ST_SRCH;
      end
      ST_DECIDE: begin
        if (stat.take) begin
          cmd.take   = 1'b1;
          state_next = ST_RD_LAST;
        end else begin
          cmd.skip   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_RD_LAST: begin
        // move the last entry into the freed slot, then recheck that slot
        cmd.rd_last = 1'b1;
        state_next  = ST_WR_SLOT;
      end
      ST_WR_SLOT: begin
        cmd.wr_slot = 1'b1;
        state_next  = ST_SCAN;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_E_RD;
      end
      ST_E_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = ST_E_LD;
      end
      ST_E_LD: begin
        cmd.emit_ld = 1'b1;
        state_next  = ST_E_WAIT;
      end
      ST_E_WAIT: begin
        if (stat.out_fire) begin
          if (stat.k_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_next    = ST_E_RD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: src/contact_level_partitioner.sv
// Contact level partitioner. Clear and append words are handled in the idle state.
// A level word scans the contact table twice; for each contact visited it searches
// a list (previous level in the first pass, new level in the second), reading each
// list entry into a register (ST_SRCH) and then comparing it (ST_CMP); a taken contact
// then has the last entry swapped into its slot (ST_RD_LAST, ST_WR_SLOT), and that
// slot is checked again. Results are buffered and emitted after both passes (remaining
// is only known then); each result word is read (ST_E_RD), loaded (ST_E_LD) and held
// until taken (ST_E_WAIT). No new word is accepted until the last result has been taken.
module contact_level_partitioner #(
  parameter int MAX_CONTACTS = 32,
  parameter int BODY_ID_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  clp_chan_if.sink   req,
  clp_chan_if.source rsp
);

  clp_pkg::ctrl_cmd_t cmd;
  clp_pkg::dp_stat_t  stat;
  logic               ready;

  assign req.ready = ready;

  clp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.data.command),
    .req_ready (ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  clp_dp #(
    .MAX_CONTACTS (MAX_CONTACTS),
    .BODY_ID_BITS (BODY_ID_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_word (req.data),
    .cmd     (cmd),
    .stat    (stat),
    .rsp     (rsp)
  );

endmodule

// File: bench/contact_level_partitioner_tb.sv
// self-checking testbench for the contact level partitioner
`timescale 1ns / 100ps
module contact_level_partitioner_tb;

  localparam int MAX_C = 32;
  localparam int STALL_LIMIT = 200000;

  typedef struct {
    logic [7:0] b1;
    logic [7:0] b2;
    logic       m1;
    logic       m2;
    logic [5:0] tag;
  } contact_s;

  typedef struct {
    clp_pkg::in_word_t  w;
    logic               chk;
    clp_pkg::out_word_t exp_word;
  } stim_row_t;

  logic clk;
  logic rst;

  clp_chan_if #(.word_t(clp_pkg::in_word_t))  req ();
  clp_chan_if #(.word_t(clp_pkg::out_word_t)) rsp ();

  contact_level_partitioner i_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  // predictor state
  contact_s   table_q[MAX_C];
  int         table_cnt;
  logic [7:0] prev_level[MAX_C];
  int         prev_cnt;

  clp_pkg::out_word_t pending_results[$];
  int         fail_cnt;
  int         idle_pct;
  int         quiet_cycles;
  logic       done_flag;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic in_set(logic [7:0] lst[MAX_C], int n, logic [7:0] b);
    for (int i = 0; i < n; i++)
      if (lst[i] == b) return 1'b1;
    return 1'b0;
  endfunction

  // partition the table and queue the result words
  task automatic partition_level(input logic nxt);
    clp_pkg::out_word_t res[$];
    clp_pkg::out_word_t r;
    logic [7:0] fresh[MAX_C];
    int         nb;
    int         i;
    logic       tk;
    logic [7:0] b;
    contact_s   c;
    nb = 0;
    i = 0;
    while (i < table_cnt) begin
      c = table_q[i];
      if (nxt) begin
        tk = in_set(prev_level, prev_cnt, c.b1) || in_set(prev_level, prev_cnt, c.b2);
        b  = in_set(prev_level, prev_cnt, c.b1) ? c.b2 : c.b1;
      end else begin
        tk = !(c.m1 && c.m2);
        b  = c.m1 ? c.b1 : c.b2;
      end
      if (tk) begin
        r = '0;
        r.has_contact = 1'b1;
        r.contact_tag = c.tag;
        r.contact_first = c.b1;
        r.contact_second = c.b2;
        r.has_body = 1'b1;
        r.level_body = b;
        res.push_back(r);
        fresh[nb] = b;
        nb++;
        table_cnt--;
        table_q[i] = table_q[table_cnt];
      end else begin
        i++;
      end
    end
    i = 0;
    while (i < table_cnt) begin
      c = table_q[i];
      if (in_set(fresh, nb, c.b1) && in_set(fresh, nb, c.b2)) begin
        r = '0;
        r.has_contact = 1'b1;
        r.contact_tag = c.tag;
        r.contact_first = c.b1;
        r.contact_second = c.b2;
        res.push_back(r);
        table_cnt--;
        table_q[i] = table_q[table_cnt];
      end else begin
        i++;
      end
    end
    for (int k = 0; k < nb; k++) prev_level[k] = fresh[k];
    prev_cnt = nb;
    if (res.size() == 0) res.push_back('0);
    foreach (res[k]) begin
      res[k].remaining = table_cnt[5:0];
      res[k].last = (k == res.size() - 1);
      pending_results.push_back(res[k]);
    end
  endtask

  task automatic model_word(input clp_pkg::in_word_t w);
    case (w.command)
      clp_pkg::CMD_CLEAR: begin
        table_cnt = 0;
      end
      clp_pkg::CMD_APPEND: begin
        if (table_cnt < MAX_C) begin
          table_q[table_cnt] = '{w.first_body, w.second_body, w.first_movable,
                                 w.second_movable, table_cnt[5:0]};
          table_cnt++;
        end
      end
      clp_pkg::CMD_STATIC: begin
        partition_level(1'b0);
      end
      default: begin
        partition_level(1'b1);
      end
    endcase
  endtask

  // valid stays high after acceptance until the next idle cycle or stop_sending
  task automatic send_word(input clp_pkg::in_word_t w);
    if (idle_pct > 0) begin
      while ($urandom_range(99) < idle_pct) begin
        req.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req.valid <= 1'b1;
    req.data  <= w;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    model_word(w);
  endtask

  task automatic stop_sending();
    req.valid <= 1'b0;
  endtask

  function automatic clp_pkg::in_word_t mk(clp_pkg::cmd_t c, int b1, int b2, bit m1,
                                            bit m2);
    clp_pkg::in_word_t w;
    w.command = c;
    w.first_body = b1[7:0];
    w.second_body = b2[7:0];
    w.first_movable = m1;
    w.second_movable = m2;
    return w;
  endfunction

  task automatic wait_drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // receiver side with random stalls, checks each accepted word
  always @(posedge clk) begin
    clp_pkg::out_word_t e;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected");
          fail_cnt++;
        end else begin
          e = pending_results.pop_front();
          if (rsp.data.has_contact !== e.has_contact) begin
            $error("has_contact exp %0d got %0d", e.has_contact, rsp.data.has_contact);
            fail_cnt++;
          end
          if (rsp.data.contact_tag !== e.contact_tag) begin
            $error("contact_tag exp %0d got %0d", e.contact_tag, rsp.data.contact_tag);
            fail_cnt++;
          end
          if (rsp.data.contact_first !== e.contact_first) begin
            $error("contact_first exp %0d got %0d", e.contact_first,
                   rsp.data.contact_first);
            fail_cnt++;
          end
          if (rsp.data.contact_second !== e.contact_second) begin
            $error("contact_second exp %0d got %0d", e.contact_second,
                   rsp.data.contact_second);
            fail_cnt++;
          end
          if (rsp.data.has_body !== e.has_body) begin
            $error("has_body exp %0d got %0d", e.has_body, rsp.data.has_body);
            fail_cnt++;
          end
          if (rsp.data.level_body !== e.level_body) begin
            $error("level_body exp %0d got %0d", e.level_body, rsp.data.level_body);
            fail_cnt++;
          end
          if (rsp.data.remaining !== e.remaining) begin
            $error("remaining exp %0d got %0d", e.remaining, rsp.data.remaining);
            fail_cnt++;
          end
          if (rsp.data.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, rsp.data.last);
            fail_cnt++;
          end
        end
      end
      rsp.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT && !done_flag) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t          rows[$];
    clp_pkg::out_word_t ew;
    int         nitems;
    int         n;
    logic [7:0] pool[8];
    rst = 1'b1;
    req.valid = 1'b0;
    req.data = '0;
    rsp.ready = 1'b0;
    fail_cnt = 0;
    idle_pct = 33;
    quiet_cycles = 0;
    done_flag = 1'b0;
    table_cnt = 0;
    prev_cnt = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table; typed expectations where obvious
    ew = '0;
    ew.last = 1'b1;
    rows.push_back('{mk(clp_pkg::CMD_STATIC, 0, 0, 0, 0), 1'b1, ew}); // empty table
    rows.push_back('{mk(clp_pkg::CMD_NEXT, 0, 0, 0, 0), 1'b1, ew});   // empty previous list
    ew = '0;
    ew.has_contact = 1'b1;
    ew.contact_first = 8'hff;
    ew.has_body = 1'b1;
    ew.level_body = 8'hff;
    ew.last = 1'b1;
    rows.push_back('{mk(clp_pkg::CMD_APPEND, 255, 0, 1, 0), 1'b0, '0});
    rows.push_back('{mk(clp_pkg::CMD_STATIC, 0, 0, 0, 0), 1'b1, ew});
    rows.push_back('{mk(clp_pkg::CMD_APPEND, 255, 7, 1, 1), 1'b0, '0});
    rows.push_back('{mk(clp_pkg::CMD_APPEND, 7, 9, 1, 1), 1'b0, '0});
    rows.push_back('{mk(clp_pkg::CMD_APPEND, 9, 255, 1, 1), 1'b0, '0});
    rows.push_back('{mk(clp_pkg::CMD_APPEND, 3, 3, 1, 1), 1'b0, '0});
    rows.push_back('{mk(clp_pkg::CMD_NEXT, 0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(clp_pkg::CMD_NEXT, 0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(clp_pkg::CMD_CLEAR, 0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(clp_pkg::CMD_APPEND, 0, 1, 0, 0), 1'b0, '0});
    rows.push_back('{mk(clp_pkg::CMD_APPEND, 2, 0, 1, 0), 1'b0, '0});
    rows.push_back('{mk(clp_pkg::CMD_APPEND, 0, 2, 1, 1), 1'b0, '0});  // neither pass takes it
    rows.push_back('{mk(clp_pkg::CMD_APPEND, 1, 1, 1, 1), 1'b0, '0});
    rows.push_back('{mk(clp_pkg::CMD_STATIC, 0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(clp_pkg::CMD_NEXT, 0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(clp_pkg::CMD_CLEAR, 0, 0, 0, 0), 1'b0, '0});
    foreach (rows[r]) begin
      if (rows[r].chk) begin
        send_word(rows[r].w);
        // typed value must agree with the predictor's
        if (pending_results.size() != 0 && pending_results[$] != rows[r].exp_word) begin
          $error("table row %0d: predictor disagrees with typed value", r);
          fail_cnt++;
        end
      end else begin
        send_word(rows[r].w);
      end
    end
    // fill past full: extra appends are dropped
    for (int k = 0; k < MAX_C + 2; k++)
      send_word(mk(clp_pkg::CMD_APPEND, k * 8, 255 - k, k[0], k[1]));
    send_word(mk(clp_pkg::CMD_STATIC, 0, 0, 0, 0));
    send_word(mk(clp_pkg::CMD_NEXT, 0, 0, 0, 0));
    stop_sending();
    wait_drain();  // sender holds off until all results are back

    // random: well-formed level sequences over a small id pool
    nitems = 0;
    while (nitems < 46) begin
      if (nitems > 15 && nitems < 30) idle_pct = 0;
      else idle_pct = 33;
      for (int k = 0; k < 8; k++) pool[k] = 8'($urandom_range(255));
      send_word(mk(clp_pkg::CMD_CLEAR, $urandom, $urandom, 1'($urandom), 1'($urandom)));
      nitems++;
      n = $urandom_range(1, 12);
      for (int k = 0; k < n; k++) begin
        send_word(mk(clp_pkg::CMD_APPEND, pool[$urandom_range(7)], pool[$urandom_range(7)],
                     ($urandom_range(99) < 70), ($urandom_range(99) < 70)));
        nitems++;
      end
      send_word(mk(clp_pkg::CMD_STATIC, $urandom, $urandom, 1'($urandom), 1'($urandom)));
      nitems++;
      for (int k = $urandom_range(1, 3); k > 0; k--) begin
        send_word(mk(clp_pkg::CMD_NEXT, $urandom, $urandom, 1'($urandom), 1'($urandom)));
        nitems++;
      end
      if ($urandom_range(3) == 0) begin
        send_word(mk(clp_pkg::cmd_t'($urandom_range(3)), $urandom, $urandom,
                     1'($urandom), 1'($urandom)));
        nitems++;
      end
    end

    stop_sending();
    wait_drain();
    done_flag = 1'b1;
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
src/clp_pkg.sv
src/clp_chan_if.sv
src/clp_dp.sv
src/clp_ctrl.sv
src/contact_level_partitioner.sv
bench/contact_level_partitioner_tb.sv
